>>> sv/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types, constants and the control store of the PID sequencer.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // Fixed field widths
  localparam int GAIN_W = 16;
  localparam int BAND_W = 15;
  localparam int ILIM_W = 30;
  localparam int OLIM_W = 31;
  localparam int OUT_W  = 32;
  localparam int REG_W  = 32;
  localparam int ADDR_W = 5;
  localparam int STEP_W = 5;

  localparam logic signed [OUT_W-1:0] S32_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] S32_MIN       = 32'sh8000_0000;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_INTEG_BAND,
    REG_INTEG_LIMIT,
    REG_DERIV_BAND,
    REG_OUTPUT_LIMIT
  } reg_idx_e;

  // Datapath operations, one per control word
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,        // take error word, form raw derivative
    OP_TERM_E,      // integral term = e
    OP_TERM_ZERO,   // integral term = 0
    OP_MUL_BAND,    // prod = (band - |e|) * e
    OP_DIV_INTEG,   // divide |prod| by integ band
    OP_TERM_QUO,    // integral term = signed quotient
    OP_INTEG_ADD,   // accumulate, saturate to 32 bits
    OP_INTEG_CLAMP, // optional integral limit
    OP_DIV_DERIV,   // |d| / 10 by reciprocal multiply
    OP_DERIV_QUO,   // d = signed quotient
    OP_MUL_PROP,    // prod = kp * e
    OP_MUL_INTEG,   // acc = prod, prod = ki * integ
    OP_MUL_DERIV,   // acc += prod, prod = kd * d
    OP_ACC_ADD,     // acc += prod
    OP_SCALE,       // drop fraction bits, round toward zero
    OP_OUT          // clamp and load output register
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_BAND_ZERO,
    C_OUT_IBAND,
    C_OUT_DBAND,
    C_DIV_BUSY,
    C_OUT_STALL
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  // Step addresses
  localparam step_t STEP_IDLE        = 5'd0;
  localparam step_t STEP_TERM_E      = 5'd1;
  localparam step_t STEP_TERM_ZERO   = 5'd2;
  localparam step_t STEP_MUL_BAND    = 5'd3;
  localparam step_t STEP_DIV_INTEG   = 5'd4;
  localparam step_t STEP_WAIT_INTEG  = 5'd5;
  localparam step_t STEP_TERM_QUO    = 5'd6;
  localparam step_t STEP_INTEG_ADD   = 5'd7;
  localparam step_t STEP_INTEG_CLAMP = 5'd8;
  localparam step_t STEP_DBAND       = 5'd9;
  localparam step_t STEP_DIV_DERIV   = 5'd10;
  localparam step_t STEP_DERIV_QUO   = 5'd11;
  localparam step_t STEP_MUL_PROP    = 5'd12;
  localparam step_t STEP_MUL_INTEG   = 5'd13;
  localparam step_t STEP_MUL_DERIV   = 5'd14;
  localparam step_t STEP_ACC_ADD     = 5'd15;
  localparam step_t STEP_SCALE       = 5'd16;
  localparam step_t STEP_OUT         = 5'd17;

  // Control word: next = cond ? tgt : nxt
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t tgt;
    step_t nxt;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:        w = '{OP_LOAD,        C_NO_INPUT,  STEP_IDLE,       STEP_TERM_E};
      STEP_TERM_E:      w = '{OP_TERM_E,      C_BAND_ZERO, STEP_INTEG_ADD,  STEP_TERM_ZERO};
      STEP_TERM_ZERO:   w = '{OP_TERM_ZERO,   C_OUT_IBAND, STEP_INTEG_ADD,  STEP_MUL_BAND};
      STEP_MUL_BAND:    w = '{OP_MUL_BAND,    C_NEVER,     STEP_IDLE,       STEP_DIV_INTEG};
      STEP_DIV_INTEG:   w = '{OP_DIV_INTEG,   C_NEVER,     STEP_IDLE,       STEP_WAIT_INTEG};
      STEP_WAIT_INTEG:  w = '{OP_NOP,         C_DIV_BUSY,  STEP_WAIT_INTEG, STEP_TERM_QUO};
      STEP_TERM_QUO:    w = '{OP_TERM_QUO,    C_NEVER,     STEP_IDLE,       STEP_INTEG_ADD};
      STEP_INTEG_ADD:   w = '{OP_INTEG_ADD,   C_NEVER,     STEP_IDLE,       STEP_INTEG_CLAMP};
      STEP_INTEG_CLAMP: w = '{OP_INTEG_CLAMP, C_NEVER,     STEP_IDLE,       STEP_DBAND};
      STEP_DBAND:       w = '{OP_NOP,         C_OUT_DBAND, STEP_MUL_PROP,   STEP_DIV_DERIV};
      STEP_DIV_DERIV:   w = '{OP_DIV_DERIV,   C_NEVER,     STEP_IDLE,       STEP_DERIV_QUO};
      STEP_DERIV_QUO:   w = '{OP_DERIV_QUO,   C_NEVER,     STEP_IDLE,       STEP_MUL_PROP};
      STEP_MUL_PROP:    w = '{OP_MUL_PROP,    C_NEVER,     STEP_IDLE,       STEP_MUL_INTEG};
      STEP_MUL_INTEG:   w = '{OP_MUL_INTEG,   C_NEVER,     STEP_IDLE,       STEP_MUL_DERIV};
      STEP_MUL_DERIV:   w = '{OP_MUL_DERIV,   C_NEVER,     STEP_IDLE,       STEP_ACC_ADD};
      STEP_ACC_ADD:     w = '{OP_ACC_ADD,     C_NEVER,     STEP_IDLE,       STEP_SCALE};
      STEP_SCALE:       w = '{OP_SCALE,       C_NEVER,     STEP_IDLE,       STEP_OUT};
      STEP_OUT:         w = '{OP_OUT,         C_OUT_STALL, STEP_OUT,        STEP_IDLE};
      default:          w = '{OP_NOP,         C_NEVER,     STEP_IDLE,       STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/ppid_div.sv
// ----------------------------------------------------------------------------
// ppid_div
// Unsigned restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in QUO_W bits (dividend < divisor * 2^QUO_W).
// ----------------------------------------------------------------------------
module ppid_div #(
  parameter int QUO_W = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [QUO_W+ppid_pkg::BAND_W-1:0]   dividend_i,
  input  logic [ppid_pkg::BAND_W-1:0]         divisor_i,
  output logic                                busy_o,
  output logic [QUO_W-1:0]                    quotient_o
);
  import ppid_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BAND_W-1:0] rem_q, rem_d;
  logic [BAND_W-1:0] dvs_q;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [BAND_W:0]   trial, dvs_ext, diff;
  logic              ge;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  // Trial subtract of the shifted remainder
  assign trial   = {rem_q, quo_q[QUO_W-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign diff    = trial - dvs_ext;
  assign ge      = (trial >= dvs_ext);

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = CNT_W'(QUO_W);
      rem_d = dividend_i[QUO_W+BAND_W-1:QUO_W];
      quo_d = dividend_i[QUO_W-1:0];
    end else if (busy_o) begin
      cnt_d = cnt_q - CNT_W'(1);
      rem_d = ge ? diff[BAND_W-1:0] : trial[BAND_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
    end
  end

  // Iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Remainder, quotient, divisor
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

endmodule

>>> sv/positional_pid_variable_integral.sv
// ----------------------------------------------------------------------------
// positional_pid_variable_integral
// The integral term may pass through the bit-serial divider (variable
//   integration, QW = max(ERROR_WIDTH, 15) quotient bits); derivative / 10
//   is a two-step reciprocal multiply. The next word is taken once the
//   result sits in the output register.
// Reset clears gains, limits, integral, previous error and the sequencer.
// ----------------------------------------------------------------------------
module positional_pid_variable_integral #(
  parameter int ERROR_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppid_pkg::ADDR_W-1:0]         paddr,
  input  logic [ppid_pkg::REG_W-1:0]          pwdata,
  output logic [ppid_pkg::REG_W-1:0]          prdata,
  output logic                                pready,
  // Error words in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((ERROR_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // error_sample
  // Control words out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ppid_pkg::OUT_W-1:0]          m_axis_tdata   // control_out
);
  import ppid_pkg::*;

  localparam int EW  = ERROR_WIDTH;
  localparam int QW  = (EW > BAND_W) ? EW : BAND_W;       // quotient bits
  localparam int NW  = QW + BAND_W;                       // dividend bits
  localparam int TW  = QW + 1;                            // signed quotient
  localparam int AEW = (EW > BAND_W + 1) ? EW : BAND_W + 1; // |e| bits
  localparam int BW  = (EW + 1 > OUT_W) ? EW + 1 : OUT_W; // multiplier B
  localparam int MAW = GAIN_W + 1;                        // multiplier A
  localparam int PW  = MAW + BW;                          // product
  localparam int AW  = PW + 2;                            // gain sum
  localparam int SW  = OUT_W + 2;                         // integral add
  localparam int RW  = 2 * EW;                            // reciprocal product
  localparam logic signed [AW-1:0] FRAC_BIAS =
    (AW'(1) << GAIN_FRAC_BITS) - AW'(1);
  // ceil(2^(EW+3) / 10): exact floor(x / 10) for every x below 2^EW
  localparam logic [EW-1:0] DIV10_MUL =
    EW'(((64'd1 << (EW + 3)) + 64'd9) / 64'd10);

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [BAND_W-1:0]        integ_band_q, deriv_band_q;
  logic [ILIM_W-1:0]        integ_limit_q;
  logic [OLIM_W-1:0]        output_limit_q;

  // Sequencer
  step_t  pc_q, pc_d;
  ucode_t uc;
  logic   cond_true;

  // Datapath
  logic signed [EW-1:0]    e_new, e_q, prev_q;
  logic signed [EW:0]      d_q, dq_ext, d_div;
  logic [EW:0]             d_mag;
  logic [RW-1:0]           rcp_d;
  logic [EW-4:0]           rcp_q;
  logic signed [TW-1:0]    term_q, q_ext, quo_s;
  logic signed [OUT_W-1:0] integ_q, isat, ilim, iclamp, out_data_q, out_lim;
  logic signed [SW-1:0]    isum;
  logic signed [AEW:0]     e_ext, ae_ext;
  logic [AEW-1:0]          ae;
  logic [BAND_W:0]         band_diff;
  logic signed [MAW-1:0]   mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    prod_d, prod_q;
  logic [PW-1:0]           prod_mag;
  logic signed [AW-1:0]    acc_q, acc_bias, acc_scaled, olim, out_hi, out_lo, y;
  logic                    band_zero, out_iband, out_dband, quo_neg;
  logic                    in_accept, out_stall, out_valid_q, out_load;
  logic                    mul_en, rcp_en, div_start, div_busy;
  logic [NW-1:0]           div_dividend;
  logic [BAND_W-1:0]       div_divisor;
  logic [QW-1:0]           div_quo;
  logic                    cfg_we;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q    <= '0;
      gain_integ_q   <= '0;
      gain_deriv_q   <= '0;
      integ_band_q   <= '0;
      integ_limit_q  <= '0;
      deriv_band_q   <= '0;
      output_limit_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_GAIN_PROP:    gain_prop_q    <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:   gain_integ_q   <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:   gain_deriv_q   <= pwdata[GAIN_W-1:0];
        REG_INTEG_BAND:   integ_band_q   <= pwdata[BAND_W-1:0];
        REG_INTEG_LIMIT:  integ_limit_q  <= pwdata[ILIM_W-1:0];
        REG_DERIV_BAND:   deriv_band_q   <= pwdata[BAND_W-1:0];
        REG_OUTPUT_LIMIT: output_limit_q <= pwdata[OLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_GAIN_PROP:    prdata = REG_W'(unsigned'(gain_prop_q));
      REG_GAIN_INTEG:   prdata = REG_W'(unsigned'(gain_integ_q));
      REG_GAIN_DERIV:   prdata = REG_W'(unsigned'(gain_deriv_q));
      REG_INTEG_BAND:   prdata = REG_W'(integ_band_q);
      REG_INTEG_LIMIT:  prdata = REG_W'(integ_limit_q);
      REG_DERIV_BAND:   prdata = REG_W'(deriv_band_q);
      REG_OUTPUT_LIMIT: prdata = REG_W'(output_limit_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s_axis_tready = (pc_q == STEP_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_stall     = out_valid_q && !m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign e_new         = s_axis_tdata[EW-1:0];

  // ---------------- status ----------------
  assign e_ext     = (AEW+1)'(e_q);
  assign ae_ext    = e_ext[AEW] ? -e_ext : e_ext;
  assign ae        = ae_ext[AEW-1:0];
  assign band_zero = (integ_band_q == '0);
  assign out_iband = (ae >= AEW'(integ_band_q));
  assign out_dband = (ae >= AEW'(deriv_band_q));

  // ---------------- sequencer ----------------
  assign uc = ucode_rom(pc_q);

  always_comb begin
    case (uc.cond)
      C_NEVER:     cond_true = 1'b0;
      C_NO_INPUT:  cond_true = !s_axis_tvalid;
      C_BAND_ZERO: cond_true = band_zero;
      C_OUT_IBAND: cond_true = out_iband;
      C_OUT_DBAND: cond_true = out_dband;
      C_DIV_BUSY:  cond_true = div_busy;
      C_OUT_STALL: cond_true = out_stall;
      default:     cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    pc_d = cond_true ? uc.tgt : uc.nxt;
  end

  // Control decode
  always_comb begin
    mul_en    = 1'b0;
    rcp_en    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (uc.op)
      OP_MUL_BAND, OP_MUL_PROP, OP_MUL_INTEG, OP_MUL_DERIV: mul_en = 1'b1;
      OP_DIV_INTEG: div_start = 1'b1;
      OP_DIV_DERIV: rcp_en    = 1'b1;
      OP_OUT:  out_load = !out_stall;
      default: ;
    endcase
  end

  // ---------------- multiplier ----------------
  assign band_diff = {1'b0, integ_band_q} - ae[BAND_W:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uc.op)
      OP_MUL_BAND: begin
        mul_a = signed'(MAW'(band_diff));
        mul_b = BW'(e_q);
      end
      OP_MUL_PROP: begin
        mul_a = MAW'(gain_prop_q);
        mul_b = BW'(e_q);
      end
      OP_MUL_INTEG: begin
        mul_a = MAW'(gain_integ_q);
        mul_b = BW'(integ_q);
      end
      OP_MUL_DERIV: begin
        mul_a = MAW'(gain_deriv_q);
        mul_b = BW'(d_q);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ---------------- divider (variable integration) ----------------
  assign prod_mag     = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign div_dividend = prod_mag[NW-1:0];
  assign div_divisor  = integ_band_q;

  ppid_div #(
    .QUO_W (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Quotient takes the sign of its numerator (truncation toward zero)
  assign quo_neg = e_q[EW-1];
  assign q_ext   = signed'({1'b0, div_quo});
  assign quo_s   = quo_neg ? -q_ext : q_ext;

  // ---------------- derivative / 10 ----------------
  // |d| < 2^EW, so the magnitude fits EW bits
  assign d_mag  = d_q[EW] ? (EW+1)'(-d_q) : (EW+1)'(d_q);
  assign rcp_d  = RW'(d_mag[EW-1:0]) * RW'(DIV10_MUL);
  assign dq_ext = signed'({4'b0000, rcp_q});
  assign d_div  = d_q[EW] ? -dq_ext : dq_ext;

  // ---------------- integral update ----------------
  assign isum = SW'(integ_q) + SW'(term_q);
  assign isat = (isum > SW'(S32_MAX)) ? S32_MAX :
                (isum < SW'(S32_MIN)) ? S32_MIN : isum[OUT_W-1:0];
  assign ilim = signed'(OUT_W'(integ_limit_q));
  assign iclamp = (integ_limit_q == '0) ? integ_q :
                  (integ_q > ilim)      ? ilim    :
                  (integ_q < -ilim)     ? -ilim   : integ_q;

  // ---------------- output scaling and clamp ----------------
  assign acc_bias   = acc_q[AW-1] ? FRAC_BIAS : '0;
  assign acc_scaled = (acc_q + acc_bias) >>> GAIN_FRAC_BITS;
  assign olim       = signed'(AW'(output_limit_q));
  assign out_hi     = (output_limit_q != '0) ? olim  : AW'(S32_MAX);
  assign out_lo     = (output_limit_q != '0) ? -olim : AW'(S32_MIN);
  assign y          = (acc_q > out_hi) ? out_hi : (acc_q < out_lo) ? out_lo : acc_q;
  assign out_lim    = signed'(OUT_W'(output_limit_q));

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      pc_q <= pc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        prev_q <= e_new;
      end
      case (uc.op)
        OP_INTEG_ADD:   integ_q <= isat;
        OP_INTEG_CLAMP: integ_q <= iclamp;
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (rcp_en) begin
      rcp_q <= rcp_d[RW-1:EW+3];
    end
    if (out_load) begin
      out_data_q <= y[OUT_W-1:0];
    end
    case (uc.op)
      OP_LOAD: begin
        if (in_accept) begin
          e_q <= e_new;
          d_q <= (EW+1)'(e_new) - (EW+1)'(prev_q);
        end
      end
      OP_TERM_E:    term_q <= TW'(e_q);
      OP_TERM_ZERO: term_q <= '0;
      OP_TERM_QUO:  term_q <= quo_s;
      OP_DERIV_QUO: d_q    <= d_div;
      OP_MUL_INTEG: acc_q  <= AW'(prod_q);
      OP_MUL_DERIV: acc_q  <= acc_q + AW'(prod_q);
      OP_ACC_ADD:   acc_q  <= acc_q + AW'(prod_q);
      OP_SCALE:     acc_q  <= acc_scaled;
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("second word taken during processing");

  a_integ_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.op == OP_INTEG_CLAMP && integ_limit_q != '0) |=>
      (integ_q <= ilim && integ_q >= -ilim))
    else $error("integral outside its limit");

  a_out_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && output_limit_q != '0) |->
      (out_data_q <= out_lim && out_data_q >= -out_lim))
    else $error("output outside its limit");

endmodule
